// File: rtl/pbdo_pkg.sv
// Shared widths, codes and record types for the priority buffer with drop-oldest.
// No dependencies; used by pbdo_front, pbdo_back and priority_buffer_drop_oldest.
package pbdo_pkg;

  localparam int ID_W  = 16;
  localparam int PRI_W = 8;
  localparam int PAY_W = 32;
  localparam int CNT_W = 5;

  localparam int DEPTH_DEFAULT = 16;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef struct packed {
    logic             is_pop;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
    logic [CNT_W-1:0] occ;
  } res_t;

endpackage

// File: rtl/pbdo_front.sv
// Front end: accepts requests, classifies push versus pop, holds them in a 2-entry queue.
// Depends on pbdo_pkg.
module pbdo_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pbdo_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output pbdo_pkg::cmd_t                cmd
);
  import pbdo_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push_q;
  logic       pop_q;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.is_pop = (s_tuser == MODE_POP);
    in_cmd.id     = s_tdata[ID_W-1:0];
    in_cmd.pri    = s_tdata[ID_W+PRI_W-1:ID_W];
    in_cmd.pay    = s_tdata[ID_W+PRI_W+PAY_W-1:ID_W+PRI_W];
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push_q    = s_tvalid && s_tready;
  assign pop_q     = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push_q) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_q) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_q) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_q, pop_q})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/pbdo_back.sv
// Back end: slot row in arrival order, best-entry scan, shift/compact and result register.
// Depends on pbdo_pkg.
module pbdo_back #(
  parameter int DEPTH = pbdo_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pbdo_pkg::CNT_W-1:0] cap,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  pbdo_pkg::cmd_t             cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pbdo_pkg::res_t             res
);
  import pbdo_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [ID_W-1:0]  slot_id       [DEPTH];
  logic [PRI_W-1:0] slot_pri      [DEPTH];
  logic [PAY_W-1:0] slot_pay      [DEPTH];
  logic [ID_W-1:0]  slot_id_next  [DEPTH];
  logic [PRI_W-1:0] slot_pri_next [DEPTH];
  logic [PAY_W-1:0] slot_pay_next [DEPTH];
  logic [ID_W-1:0]  up_id         [DEPTH];
  logic [PRI_W-1:0] up_pri        [DEPTH];
  logic [PAY_W-1:0] up_pay        [DEPTH];

  logic [1:0]       state;
  logic [CNT_W-1:0] n;
  logic [CMP_W-1:0] n_ext;
  logic [CMP_W-1:0] scan;
  logic [CMP_W-1:0] best_idx;
  logic [ID_W-1:0]  best_id;
  logic [PRI_W-1:0] best_pri;
  logic [PAY_W-1:0] best_pay;
  logic [ID_W-1:0]  rd_id;
  logic [PRI_W-1:0] rd_pri;
  logic [PAY_W-1:0] rd_pay;

  logic             out_free;
  logic             take;
  logic             full;
  logic             do_shift;
  logic [CMP_W-1:0] shift_lo;
  logic             do_write;
  logic [CMP_W-1:0] wpos;
  logic             res_load;
  logic             emit;
  res_t             res_next;

  assign n_ext    = CMP_W'(n);
  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_IDLE) && cmd_valid && out_free;
  assign cmd_ready = take;
  assign full     = (n >= cap);
  assign res_load = take || (state == ST_EMIT && out_free);
  assign emit     = (take && (!cmd.is_pop || n == '0)) || (state == ST_EMIT && out_free);

  assign rd_id  = slot_id[scan[IDX_W-1:0]];
  assign rd_pri = slot_pri[scan[IDX_W-1:0]];
  assign rd_pay = slot_pay[scan[IDX_W-1:0]];

  // shift and write controls for the slot row
  always_comb begin
    do_shift = 1'b0;
    shift_lo = '0;
    do_write = 1'b0;
    wpos     = '0;
    if (take && !cmd.is_pop) begin
      do_write = 1'b1;
      if (full) begin
        do_shift = 1'b1;
        wpos     = n_ext - CMP_W'(1);
      end else begin
        wpos     = n_ext;
      end
    end else if (state == ST_EMIT && out_free && best_id != '0) begin
      do_shift = 1'b1;
      shift_lo = best_idx;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      up_id[i]  = slot_id[i+1];
      up_pri[i] = slot_pri[i+1];
      up_pay[i] = slot_pay[i+1];
    end
    up_id[DEPTH-1]  = slot_id[DEPTH-1];
    up_pri[DEPTH-1] = slot_pri[DEPTH-1];
    up_pay[DEPTH-1] = slot_pay[DEPTH-1];
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_id_next[i]  = slot_id[i];
      slot_pri_next[i] = slot_pri[i];
      slot_pay_next[i] = slot_pay[i];
      if (do_shift && CMP_W'(i) >= shift_lo && CMP_W'(i) + CMP_W'(1) < n_ext) begin
        slot_id_next[i]  = up_id[i];
        slot_pri_next[i] = up_pri[i];
        slot_pay_next[i] = up_pay[i];
      end
      if (do_write && CMP_W'(i) == wpos) begin
        slot_id_next[i]  = cmd.id;
        slot_pri_next[i] = cmd.pri;
        slot_pay_next[i] = cmd.pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_id[i]  <= slot_id_next[i];
      slot_pri[i] <= slot_pri_next[i];
      slot_pay[i] <= slot_pay_next[i];
    end
  end

  // result record for the request being finished
  always_comb begin
    res_next = '0;
    if (take) begin
      if (!cmd.is_pop) begin
        if (full) begin
          res_next.valid = 1'b1;
          res_next.id    = slot_id[0];
          res_next.pri   = slot_pri[0];
          res_next.pay   = slot_pay[0];
          res_next.occ   = n;
        end else begin
          res_next.occ = n + CNT_W'(1);
        end
      end else begin
        res_next.occ = n;
      end
    end else if (best_id != '0) begin
      res_next.valid = 1'b1;
      res_next.id    = best_id;
      res_next.pri   = best_pri;
      res_next.pay   = best_pay;
      res_next.occ   = n - CNT_W'(1);
    end else begin
      res_next.occ = n;
    end
  end

  // scan registers and result payload
  always_ff @(posedge clk) begin
    if (take && cmd.is_pop) begin
      best_id  <= slot_id[0];
      best_pri <= slot_pri[0];
      best_pay <= slot_pay[0];
      best_idx <= '0;
      scan     <= CMP_W'(1);
    end else if (state == ST_SCAN && scan < n_ext) begin
      if (rd_pri < best_pri || (rd_pri == best_pri && rd_id < best_id)) begin
        best_id  <= rd_id;
        best_pri <= rd_pri;
        best_pay <= rd_pay;
        best_idx <= scan;
      end
      scan <= scan + CMP_W'(1);
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (!cmd.is_pop) begin
              if (!full) begin
                n <= n + CNT_W'(1);
              end
            end else if (n != '0) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan >= n_ext) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (best_id != '0) begin
              n <= n - CNT_W'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/priority_buffer_drop_oldest.sv
// Top level of the priority buffer with drop-oldest eviction.
// Depends on pbdo_pkg, pbdo_front and pbdo_back.
//
// Holds up to capacity_in_use requests (id, priority, payload) in arrival
// order and returns exactly one result for every request. A push (tuser 0)
// appends; when the buffer is full it drops the oldest entry and returns it
// with entry_valid set. A pop (tuser 1) returns the entry with the smallest
// priority, ties broken by smallest id then by age, and compacts the store;
// an empty buffer or a selected id of zero returns not-found. Requests pass
// through a 2-entry queue, so the input can take up to two requests while
// the engine works or the output stalls. A push, or a pop of an empty
// buffer, is finished when the engine takes it. Any other pop is taken,
// then the single-port scan of the slot row reads one entry per cycle
// to find the best one, and an emit step shifts the row and loads the
// result register once the output is free. Capacity writes (5 bits,
// 0 acts as 1, values above DEPTH saturate) belong to idle periods.
module priority_buffer_drop_oldest #(
  parameter int DEPTH = pbdo_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pbdo_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata, low bit up: req_id[15:0], req_priority[23:16], req_payload[55:24]
  input  logic [pbdo_pkg::IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: mode (0 push, 1 pop)
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata, low bit up: entry_id[15:0], entry_priority[23:16],
  // entry_payload[55:24], occupancy[60:56], zeros[63:61]
  output logic [pbdo_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: entry_valid
  output logic                             m_tuser
);
  import pbdo_pkg::*;

  // largest capacity the slot row and the count can hold
  localparam int CAP_MAX = (DEPTH > 31) ? 31 : DEPTH;

  logic [CNT_W-1:0] capacity_in_use;
  logic [CNT_W-1:0] cap_eff;
  logic             cmd_valid;
  logic             cmd_ready;
  cmd_t             cmd;
  res_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  // clamp the register into the usable range
  always_comb begin
    if (capacity_in_use == '0) begin
      cap_eff = CNT_W'(1);
    end else if (capacity_in_use > CNT_W'(CAP_MAX)) begin
      cap_eff = CNT_W'(CAP_MAX);
    end else begin
      cap_eff = capacity_in_use;
    end
  end

  pbdo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  pbdo_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap_eff),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  // pack the result record onto the stream
  assign m_tuser = res.valid;
  assign m_tdata = {3'b000, res.occ, res.pay, res.pri, res.id};

endmodule
